[rtl/sample_store_resampling_reader_unit_defines.svh]
// Assertion macros used by the reader unit RTL.
`ifndef SAMPLE_STORE_RESAMPLING_READER_UNIT_DEFINES_SVH
`define SAMPLE_STORE_RESAMPLING_READER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SSR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SSR_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/ssr_pkg.sv]
package ssr_pkg;

   // Command codes of an input beat.
   localparam logic [1:0] CMD_APPEND   = 2'd0;
   localparam logic [1:0] CMD_READ     = 2'd1;
   localparam logic [1:0] CMD_TRUNCATE = 2'd2;
   localparam logic [1:0] CMD_UNKNOWN  = 2'd3;

   // Interpolation modes.
   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_CONST  = 2'd1;
   localparam logic [1:0] MODE_LINEAR = 2'd2;
   localparam logic [1:0] MODE_SPARE  = 2'd3;

   // Register indexes.
   localparam logic CSR_SOURCE_RATE = 1'b0;
   localparam logic CSR_INTERP_MODE = 1'b1;

   // Frame store depth; the 17-bit length ports are sized for it.
   localparam int STORE_DEPTH = 65536;

   localparam logic [18:0] SOURCE_RATE_RESET = 19'd44100;
   localparam logic [23:0] RATIO_MAX = 24'hFFFFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_BASE,
      ST_CHECK,
      ST_POS,
      ST_FETCH_A,
      ST_FETCH_B,
      ST_BLEND,
      ST_EMIT,
      ST_SINGLE
   } state_type;

endpackage

[rtl/sample_store_resampling_reader_unit.sv]
// Channel   | Ports                                  | Direction
// command   | start, busy, req_*                     | in, busy out
// result    | rsp_valid, rsp_*                       | out
// config    | csr_write, csr_index, csr_data         | in
//
// Append, truncate and unknown commands keep busy high for one cycle; the result follows.
// A resampling read runs a restoring divide of the ratio, then a shift-add for the base
// and a check state, then per frame a position, a fetch and an emit state, plus a second
// fetch and a blend state when two frames are blended, as the single memory read port allows.
// A plain copy passes the divide state once in place of divide and base, without blending.
// Results cannot be stalled. Reset clears the length and registers, not the frame memory.
`include "sample_store_resampling_reader_unit_defines.svh"

module sample_store_resampling_reader_unit #(
   parameter int MAX_BURST   = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_cmd,
   input  logic signed [15:0]  req_frame_value,
   input  logic [15:0]         req_start_offset,
   input  logic [6:0]          req_count,
   input  logic [18:0]         req_read_rate,
   input  logic [16:0]         req_new_length,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [18:0]         csr_data,
   output logic                rsp_valid,
   output logic signed [15:0]  rsp_sample_out,
   output logic [16:0]         rsp_stored_length,
   output logic                rsp_no_data,
   output logic                rsp_dropped,
   output logic                rsp_last
);

   localparam int AW = $clog2(ssr_pkg::STORE_DEPTH);
   localparam logic [6:0] BURST_MAX = 7'(MAX_BURST);
   localparam logic [6:0] IDX_NONE  = 7'd127;
   localparam int SAT_SHIFT = (SAMPLE_BITS < 16) ? (16 - SAMPLE_BITS) : 0;
   localparam logic signed [15:0] SAT_HI = 16'sd32767 >>> SAT_SHIFT;
   localparam logic signed [15:0] SAT_LO = -SAT_HI - 16'sd1;

   // Frame memory, one write or one read per cycle.
   logic signed [15:0] mem [ssr_pkg::STORE_DEPTH];
   logic signed [15:0] rdata_ff;
   logic [AW-1:0]      raddr;
   logic               mem_rd;
   logic               mem_wr;

   ssr_pkg::state_type state_ff, state_in;

   logic [18:0] source_rate_ff;
   logic [1:0]  interp_mode_ff;
   logic [16:0] len_ff, len_in;

   // Command latch.
   logic [1:0]  cmd_ff;
   logic [15:0] offset_ff;
   logic [6:0]  count_ff;
   logic [18:0] rate_ff;
   logic        copy_ff;
   logic [16:0] req_new_length_ff;
   logic signed [15:0] frame_ff;

   // Shared divider / shift-add datapath.
   logic [40:0] rem_ff, rem_in;
   logic [34:0] quo_ff, quo_in;
   logic [5:0]  step_ff, step_in;
   logic [23:0] ratio_ff, ratio_in;
   logic [39:0] acc_ff, acc_in;
   logic [39:0] pos_ff, pos_in;
   logic [6:0]  idx_ff, idx_in;
   logic signed [15:0] a_ff, a_in;
   logic signed [47:0] bl_ff, bl_in;
   logic        emitted_ff, emitted_in;

   // Result register.
   logic        rv_ff, rv_in;
   logic signed [15:0] rs_ff, rs_in;
   logic        rnd_ff, rnd_in, rdr_ff, rdr_in, rl_ff, rl_in;

   logic [6:0]  cnt_eff;
   logic [39:0] avail;
   logic [39:0] f1;
   logic [15:0] frac;
   logic        more;
   logic [40:0] rem_try;
   logic signed [15:0] clamped;

   assign cnt_eff = (count_ff > BURST_MAX) ? BURST_MAX : count_ff;
   assign avail   = 40'(len_ff) - acc_ff;
   assign f1      = {16'd0, pos_ff[39:16]};
   assign frac    = pos_ff[15:0];
   assign rem_try = {rem_ff[39:0], quo_ff[34]} - {22'd0, rate_ff};
   assign clamped = (req_frame_value > SAT_HI) ? SAT_HI :
                    (req_frame_value < SAT_LO) ? SAT_LO : req_frame_value;

   // Memory port.
   always_ff @(posedge clock) begin
      if (mem_wr) mem[len_ff[AW-1:0]] <= frame_ff;
      if (mem_rd) rdata_ff <= mem[raddr];
   end

   // Register file and control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ssr_pkg::ST_IDLE;
         source_rate_ff <= ssr_pkg::SOURCE_RATE_RESET;
         interp_mode_ff <= ssr_pkg::MODE_NONE;
         len_ff         <= '0;
         rv_ff          <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         rv_ff    <= rv_in;
         if (csr_write) begin
            unique case (csr_index)
               ssr_pkg::CSR_SOURCE_RATE: source_rate_ff <= csr_data;
               ssr_pkg::CSR_INTERP_MODE: interp_mode_ff <= csr_data[1:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         cmd_ff    <= req_cmd;
         offset_ff <= req_start_offset;
         count_ff  <= req_count;
         rate_ff   <= req_read_rate;
         copy_ff   <= (req_read_rate == 19'd0) || (req_read_rate == source_rate_ff) ||
                      (interp_mode_ff == ssr_pkg::MODE_NONE) ||
                      (interp_mode_ff == ssr_pkg::MODE_SPARE);
      end
      rem_ff <= rem_in; quo_ff <= quo_in; step_ff <= step_in;
      ratio_ff <= ratio_in; acc_ff <= acc_in; pos_ff <= pos_in;
      idx_ff <= idx_in; a_ff <= a_in; bl_ff <= bl_in; emitted_ff <= emitted_in;
      rs_ff <= rs_in; rnd_ff <= rnd_in; rdr_ff <= rdr_in; rl_ff <= rl_in;
   end

   assign more = (f1 < avail) && (idx_ff < cnt_eff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssr_pkg::ST_IDLE:
            if (start) state_in = (req_cmd == ssr_pkg::CMD_READ) ? ssr_pkg::ST_DIV
                                                                 : ssr_pkg::ST_SINGLE;
         ssr_pkg::ST_DIV:
            if (copy_ff) state_in = ssr_pkg::ST_CHECK;
            else if (step_ff == 6'd35) state_in = ssr_pkg::ST_BASE;
         ssr_pkg::ST_BASE:
            if (step_ff == 6'd16) state_in = ssr_pkg::ST_CHECK;
         ssr_pkg::ST_CHECK:  state_in = ssr_pkg::ST_POS;
         ssr_pkg::ST_POS:
            state_in = more ? ssr_pkg::ST_FETCH_A : ssr_pkg::ST_EMIT;
         ssr_pkg::ST_FETCH_A:
            state_in = (!copy_ff && interp_mode_ff == ssr_pkg::MODE_LINEAR &&
                        frac != 16'd0 && (f1 + 40'd1) < avail)
                       ? ssr_pkg::ST_FETCH_B : ssr_pkg::ST_EMIT;
         ssr_pkg::ST_FETCH_B: state_in = ssr_pkg::ST_BLEND;
         ssr_pkg::ST_BLEND:   state_in = ssr_pkg::ST_EMIT;
         ssr_pkg::ST_EMIT:
            state_in = (rl_in) ? ssr_pkg::ST_IDLE : ssr_pkg::ST_POS;
         ssr_pkg::ST_SINGLE:  state_in = ssr_pkg::ST_IDLE;
         default:             state_in = ssr_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      len_in = len_ff; rem_in = rem_ff; quo_in = quo_ff; step_in = step_ff;
      ratio_in = ratio_ff; acc_in = acc_ff; pos_in = pos_ff; idx_in = idx_ff;
      a_in = a_ff; bl_in = bl_ff; emitted_in = emitted_ff;
      rv_in = 1'b0; rs_in = rs_ff; rnd_in = 1'b0; rdr_in = 1'b0; rl_in = 1'b0;
      mem_rd = 1'b0; mem_wr = 1'b0; raddr = '0;
      unique case (state_ff)
         ssr_pkg::ST_IDLE: begin
            quo_in = {req_read_rate == 19'd0 ? 19'd0 : source_rate_ff, 16'd0};
            rem_in = '0; step_in = '0; idx_in = '0; emitted_in = 1'b0;
            acc_in = '0; pos_in = '0;
         end
         ssr_pkg::ST_DIV: begin
            // One quotient bit a cycle.
            if (!rem_try[40]) rem_in = rem_try;
            else rem_in = {rem_ff[39:0], quo_ff[34]};
            quo_in = {quo_ff[33:0], !rem_try[40]};
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd35) begin
               ratio_in = (quo_ff[34:24] != '0) ? ssr_pkg::RATIO_MAX : quo_ff[23:0];
               step_in = '0; acc_in = '0;
            end
            if (copy_ff) begin
               ratio_in = 24'h010000;
               acc_in = {24'd0, offset_ff};
            end
         end
         ssr_pkg::ST_BASE: begin
            // Shift-add multiply of offset by ratio, MSB first.
            if (step_ff < 6'd16) begin
               acc_in = (acc_ff << 1) +
                        (offset_ff[4'd15 - step_ff[3:0]] ? {16'd0, ratio_ff} : 40'd0);
               step_in = step_ff + 6'd1;
            end else acc_in = acc_ff >> 16;
         end
         ssr_pkg::ST_CHECK: begin
            pos_in = '0;
            if (ratio_ff == '0 || count_ff == '0 || acc_ff >= 40'(len_ff))
               idx_in = IDX_NONE;
         end
         ssr_pkg::ST_POS: begin
            raddr = AW'(acc_ff + f1);
            mem_rd = more;
            if (!more) begin
               rv_in = 1'b0;
            end
         end
         ssr_pkg::ST_FETCH_A: begin
            a_in = rdata_ff;
            raddr = AW'(acc_ff + f1 + 40'd1);
            mem_rd = 1'b1;
         end
         ssr_pkg::ST_FETCH_B:
            bl_in = 48'(a_ff) * 48'(17'h10000 - 17'(frac)) + 48'(rdata_ff) * 48'(frac);
         ssr_pkg::ST_BLEND:
            bl_in = (bl_ff + 48'sd32768) >>> 16;
         ssr_pkg::ST_EMIT: begin
            // Chained emits: the next position decides whether this is last.
            if (idx_ff == IDX_NONE || (!emitted_ff && !more)) begin
               rv_in = 1'b1; rs_in = '0; rnd_in = 1'b1; rl_in = 1'b1;
            end else if (more) begin
               rv_in = 1'b1;
               idx_in = idx_ff + 7'd1;
               pos_in = pos_ff + {16'd0, ratio_ff};
               emitted_in = 1'b1;
               rl_in = ((idx_ff + 7'd1) >= cnt_eff) ||
                       ({16'd0, pos_in[39:16]} >= avail);
            end else begin
               rl_in = 1'b1;
            end
         end
         ssr_pkg::ST_SINGLE: begin
            rv_in = 1'b1; rs_in = '0; rl_in = 1'b1;
            if (cmd_ff == ssr_pkg::CMD_APPEND) begin
               if (len_ff >= 17'(ssr_pkg::STORE_DEPTH)) rdr_in = 1'b1;
               else begin mem_wr = 1'b1; len_in = len_ff + 17'd1; end
            end else if (cmd_ff == ssr_pkg::CMD_TRUNCATE) begin
               if (req_new_length_ff < len_ff) len_in = req_new_length_ff;
            end
         end
         default: ;
      endcase
      // Sample value for the result about to be emitted.
      if (state_ff == ssr_pkg::ST_FETCH_A) rs_in = rdata_ff;
      if (state_ff == ssr_pkg::ST_BLEND) rs_in = 16'((bl_ff + 48'sd32768) >>> 16);
   end

   // Append and truncate operands held for the single-result cycle.
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_new_length_ff <= req_new_length;
         frame_ff <= clamped;
      end
   end

   assign busy              = (state_ff != ssr_pkg::ST_IDLE);
   assign rsp_valid         = rv_ff;
   assign rsp_sample_out    = rs_ff & {16{!rnd_ff}};
   assign rsp_stored_length = len_ff;
   assign rsp_no_data       = rnd_ff;
   assign rsp_dropped       = rdr_ff;
   assign rsp_last          = rl_ff;

   `SSR_ASSERT_IMPL(a_last_valid, clock, reset, rsp_last, rsp_valid, "last without strobe")
   `SSR_ASSERT_IMPL(a_nd_zero, clock, reset, rsp_valid && rsp_no_data, rsp_sample_out == 16'sd0,
                    "no_data with nonzero sample")
   `SSR_ASSERT_NEXT(a_len_cap, clock, reset, 1'b1, len_ff <= 17'(ssr_pkg::STORE_DEPTH),
                    "length overflow")

endmodule
